/* hw/rtl/lfowd_pkg.sv */
package lfowd_pkg;

  localparam int MAX_DUTY_DEF = 255;

  // kinematic constants Q2.15; GAIN_ONE is Q1.14
  localparam logic signed [16:0] Q_SIN60 = 17'sd28378;
  localparam logic signed [16:0] Q_HALF  = 17'sd16384;
  localparam logic signed [16:0] Q_TENTH = 17'sd3277;
  localparam logic signed [16:0] Q_ONE   = 17'sd32768;
  localparam logic signed [16:0] GAIN_ONE = 17'sd16384;

  localparam logic [11:0] PULSE_STRAIGHT = 12'd5;
  localparam logic [11:0] PULSE_MICRO    = 12'd2;
  localparam logic [11:0] PULSE_MACRO    = 12'd3;
  localparam logic [11:0] PULSE_SEARCH   = 12'd10;

  localparam logic [1:0] DIR_OFF = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;

  localparam logic OP_LINE = 1'b0;
  localparam logic OP_VEL  = 1'b1;

  localparam logic [1:0] WHEEL_LEFT  = 2'd0;
  localparam logic [1:0] WHEEL_RIGHT = 2'd1;
  localparam logic [1:0] WHEEL_REAR  = 2'd2;

  localparam logic [1:0] TERM_VX = 2'd0;
  localparam logic [1:0] TERM_VY = 2'd1;
  localparam logic [1:0] TERM_W  = 2'd2;

  localparam logic [2:0] CFG_CRUISE_SPEED = 3'd0;
  localparam logic [2:0] CFG_AVOIDED_MODE = 3'd1;
  localparam logic [2:0] CFG_TURN_SMALL   = 3'd2;
  localparam logic [2:0] CFG_TURN_LARGE   = 3'd3;
  localparam logic [2:0] CFG_TURN_SEARCH  = 3'd4;
  localparam logic [2:0] CFG_GAIN_FRONT   = 3'd5;
  localparam logic [2:0] CFG_GAIN_REAR    = 3'd6;

  localparam int ACC_W = 42;
  localparam int SUM_W = 26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_GAIN,
    ST_ROUND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [9:0] vy;
    logic signed [9:0] w;
    logic [11:0]       pulse;
    logic              stop;
    logic              turn_upd;
    logic              turn_right;
  } line_cmd_t;

  // wheel coefficient for one term of the inverse kinematics
  function automatic logic signed [16:0] coef(input logic [1:0] wheel, input logic [1:0] term);
    logic signed [16:0] c;
    c = '0;
    unique case (wheel)
      WHEEL_LEFT: begin
        case (term)
          TERM_VX: c = -Q_SIN60;
          TERM_VY: c = Q_HALF;
          TERM_W:  c = Q_TENTH;
          default: c = '0;
        endcase
      end
      WHEEL_RIGHT: begin
        case (term)
          TERM_VX: c = Q_SIN60;
          TERM_VY: c = Q_HALF;
          TERM_W:  c = -Q_TENTH;
          default: c = '0;
        endcase
      end
      WHEEL_REAR: begin
        case (term)
          TERM_VX: c = Q_ONE;
          TERM_W:  c = Q_TENTH;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/lfowd_mac.sv */
module lfowd_mac (
  input  logic                                      clk,
  input  lfowd_pkg::mac_ctrl_t                      ctrl,
  input  logic signed [lfowd_pkg::SUM_W-1:0]        mul_a,
  input  logic signed [16:0]                        mul_b,
  output logic signed [lfowd_pkg::ACC_W-1:0]        acc
);

  logic signed [lfowd_pkg::SUM_W+16:0] prod;
  logic signed [lfowd_pkg::ACC_W-1:0]  acc_r;
  logic signed [lfowd_pkg::ACC_W-1:0]  acc_nxt;

  assign prod = mul_a * mul_b;

  always_comb begin
    acc_nxt = (ctrl.clr ? '0 : acc_r) + prod[lfowd_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

/* hw/rtl/lfowd_decode.sv */
module lfowd_decode (
  input  logic [3:0]            sensor_levels,
  input  logic [7:0]            cruise_speed,
  input  logic                  avoided_mode,
  input  logic [8:0]            turn_small,
  input  logic [8:0]            turn_large,
  input  logic [8:0]            turn_search,
  input  logic                  last_right,
  output lfowd_pkg::line_cmd_t  cmd
);

  logic [3:0]        code;
  logic signed [9:0] base_s;
  logic signed [9:0] search_s;

  assign code     = ~sensor_levels;
  assign base_s   = signed'({2'b00, cruise_speed});
  assign search_s = last_right ? signed'({1'b0, turn_search}) : -signed'({1'b0, turn_search});

  always_comb begin
    cmd            = '0;
    cmd.turn_right = 1'b0;
    unique case (code) inside
      4'h6: begin
        cmd.vy    = base_s;
        cmd.pulse = lfowd_pkg::PULSE_STRAIGHT;
      end
      4'h4: begin
        cmd.turn_upd = 1'b1;
        cmd.vy       = base_s;
        cmd.w        = -signed'({1'b0, turn_small});
        cmd.pulse    = lfowd_pkg::PULSE_MICRO;
      end
      4'h8, 4'hC, 4'hE: begin
        cmd.turn_upd = 1'b1;
        cmd.vy       = base_s;
        cmd.w        = -signed'({1'b0, turn_large});
        cmd.pulse    = lfowd_pkg::PULSE_MACRO;
      end
      4'h2: begin
        cmd.turn_upd   = 1'b1;
        cmd.turn_right = 1'b1;
        cmd.vy         = base_s;
        cmd.w          = signed'({1'b0, turn_small});
        cmd.pulse      = lfowd_pkg::PULSE_MICRO;
      end
      4'h1, 4'h3, 4'h7: begin
        cmd.turn_upd   = 1'b1;
        cmd.turn_right = 1'b1;
        cmd.vy         = base_s;
        cmd.w          = signed'({1'b0, turn_large});
        cmd.pulse      = lfowd_pkg::PULSE_MACRO;
      end
      4'h0: begin
        cmd.w     = search_s;
        cmd.pulse = lfowd_pkg::PULSE_SEARCH;
      end
      4'hF: begin
        // all black: finish line when in avoided mode
        if (avoided_mode) begin
          cmd.stop = 1'b1;
        end else begin
          cmd.vy    = base_s;
          cmd.pulse = lfowd_pkg::PULSE_STRAIGHT;
        end
      end
      default: begin
        cmd.w     = search_s;
        cmd.pulse = lfowd_pkg::PULSE_STRAIGHT;
      end
    endcase
  end

endmodule

/* hw/rtl/line_follow_omni_wheel_drive_core.sv */
// sequence per drive item: for each of 3 wheels, 3 multiply-accumulates, 1 gain
//   multiply and 1 rounding step, then the output register; the all-black finish
//   goes straight to the output register
// items taken only when idle, one at a time; the single multiplier is shared
// reset: synchronous active-low rst_n loads register defaults, clears the turn side
//   to left and empties the output register
module line_follow_omni_wheel_drive_core #(
  parameter int MAX_DUTY = lfowd_pkg::MAX_DUTY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sensor_levels[3:0], vel_x[13:4], vel_y[23:14], turn_rate[33:24], run_ms[45:34]
  input  logic [47:0] in_tdata,
  // op[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // duty_left[7:0], dir_left[9:8], duty_right[17:10], dir_right[19:18],
  // duty_rear[27:20], dir_rear[29:28], pulse_ms[41:30], finished[42]
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);

  localparam logic [15:0] MaxDutyW = 16'(MAX_DUTY);
  localparam int AccW = lfowd_pkg::ACC_W;
  localparam int SumW = lfowd_pkg::SUM_W;

  lfowd_pkg::state_t st_r, st_nxt;

  logic [7:0]  cruise_speed_r;
  logic        avoided_mode_r;
  logic [8:0]  turn_small_r;
  logic [8:0]  turn_large_r;
  logic [8:0]  turn_search_r;
  logic [14:0] gain_front_r;
  logic [14:0] gain_rear_r;
  logic        last_right_r;

  logic signed [9:0] vx_r, vy_r, w_r;
  logic [11:0]       pulse_r;
  logic              fin_r;
  logic              strafe_r;
  logic [1:0]        wheel_r;
  logic [1:0]        term_r;
  logic [7:0]        duty_r [3];
  logic [1:0]        dir_r [3];

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;

  logic                 in_fire;
  logic                 out_free;
  lfowd_pkg::line_cmd_t cmd;
  lfowd_pkg::mac_ctrl_t mac_ctrl;
  logic signed [SumW-1:0] mac_a;
  logic signed [16:0]     mac_b;
  logic signed [AccW-1:0] acc;
  logic signed [9:0]      term_op;
  logic signed [16:0]     gain_s;

  logic [AccW-1:0] mag;
  logic [AccW-1:0] mag_rnd;
  logic [12:0]     rnd;
  logic [15:0]     sat;
  logic [7:0]      duty_w;
  logic [1:0]      dir_w;

  logic signed [9:0] in_vx, in_vy, in_w;

  assign in_vx = signed'(in_tdata[13:4]);
  assign in_vy = signed'(in_tdata[23:14]);
  assign in_w  = signed'(in_tdata[33:24]);

  assign in_tready = (st_r == lfowd_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  lfowd_decode u_decode (
    .sensor_levels (in_tdata[3:0]),
    .cruise_speed  (cruise_speed_r),
    .avoided_mode  (avoided_mode_r),
    .turn_small    (turn_small_r),
    .turn_large    (turn_large_r),
    .turn_search   (turn_search_r),
    .last_right    (last_right_r),
    .cmd           (cmd)
  );

  lfowd_mac u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .mul_a (mac_a),
    .mul_b (mac_b),
    .acc   (acc)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lfowd_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == lfowd_pkg::OP_LINE && cmd.stop) begin
            st_nxt = lfowd_pkg::ST_OUT;
          end else begin
            st_nxt = lfowd_pkg::ST_MAC;
          end
        end
      end
      lfowd_pkg::ST_MAC: begin
        if (term_r == lfowd_pkg::TERM_W) begin
          st_nxt = lfowd_pkg::ST_GAIN;
        end
      end
      lfowd_pkg::ST_GAIN:  st_nxt = lfowd_pkg::ST_ROUND;
      lfowd_pkg::ST_ROUND: begin
        st_nxt = (wheel_r == lfowd_pkg::WHEEL_REAR) ? lfowd_pkg::ST_OUT : lfowd_pkg::ST_MAC;
      end
      lfowd_pkg::ST_OUT: begin
        if (out_free) begin
          st_nxt = lfowd_pkg::ST_IDLE;
        end
      end
      default: st_nxt = lfowd_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    mac_ctrl = '0;
    case (term_r)
      lfowd_pkg::TERM_VX: term_op = vx_r;
      lfowd_pkg::TERM_VY: term_op = vy_r;
      default:            term_op = w_r;
    endcase
    if (strafe_r) begin
      gain_s = (wheel_r == lfowd_pkg::WHEEL_REAR) ? signed'({2'b00, gain_rear_r})
                                                  : signed'({2'b00, gain_front_r});
    end else begin
      gain_s = lfowd_pkg::GAIN_ONE;
    end
    mac_a = SumW'(term_op);
    mac_b = lfowd_pkg::coef(wheel_r, term_r);
    unique case (st_r)
      lfowd_pkg::ST_MAC: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.clr = (term_r == lfowd_pkg::TERM_VX);
      end
      lfowd_pkg::ST_GAIN: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.clr = 1'b1;
        mac_a        = acc[SumW-1:0];
        mac_b        = gain_s;
      end
      default: mac_ctrl = '0;
    endcase
  end

  // round half away from zero out of Q29, saturate, split
  always_comb begin
    mag     = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
    mag_rnd = mag + (AccW'(1) << 28);
    rnd     = mag_rnd[AccW-1:29];
    sat     = ({3'b000, rnd} > MaxDutyW) ? MaxDutyW : {3'b000, rnd};
    duty_w  = sat[7:0];
    if (rnd == '0) begin
      dir_w = lfowd_pkg::DIR_OFF;
    end else begin
      dir_w = acc[AccW-1] ? lfowd_pkg::DIR_REV : lfowd_pkg::DIR_FWD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= lfowd_pkg::ST_IDLE;
      out_tvalid_r   <= 1'b0;
      cruise_speed_r <= 8'd80;
      avoided_mode_r <= 1'b0;
      turn_small_r   <= 9'd12;
      turn_large_r   <= 9'd15;
      turn_search_r  <= 9'd300;
      gain_front_r   <= 15'd13926;
      gain_rear_r    <= 15'd18678;
      last_right_r   <= 1'b0;
      wheel_r        <= '0;
      term_r         <= '0;
    end else begin
      st_r <= st_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          lfowd_pkg::CFG_CRUISE_SPEED: cruise_speed_r <= cfg_wdata[7:0];
          lfowd_pkg::CFG_AVOIDED_MODE: avoided_mode_r <= cfg_wdata[0];
          lfowd_pkg::CFG_TURN_SMALL:   turn_small_r   <= cfg_wdata[8:0];
          lfowd_pkg::CFG_TURN_LARGE:   turn_large_r   <= cfg_wdata[8:0];
          lfowd_pkg::CFG_TURN_SEARCH:  turn_search_r  <= cfg_wdata[8:0];
          lfowd_pkg::CFG_GAIN_FRONT:   gain_front_r   <= cfg_wdata;
          lfowd_pkg::CFG_GAIN_REAR:    gain_rear_r    <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_fire) begin
        wheel_r <= lfowd_pkg::WHEEL_LEFT;
        term_r  <= lfowd_pkg::TERM_VX;
        if (in_tuser == lfowd_pkg::OP_LINE && cmd.turn_upd) begin
          last_right_r <= cmd.turn_right;
        end
      end else if (st_r == lfowd_pkg::ST_MAC) begin
        term_r <= (term_r == lfowd_pkg::TERM_W) ? lfowd_pkg::TERM_VX : term_r + 2'd1;
      end else if (st_r == lfowd_pkg::ST_ROUND) begin
        wheel_r <= wheel_r + 2'd1;
      end

      if (st_r == lfowd_pkg::ST_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        duty_r[i] <= '0;
        dir_r[i]  <= lfowd_pkg::DIR_OFF;
      end
      if (in_tuser == lfowd_pkg::OP_VEL) begin
        vx_r    <= in_vx;
        vy_r    <= in_vy;
        w_r     <= in_w;
        pulse_r <= in_tdata[45:34];
        fin_r   <= 1'b0;
        // pure strafe picks up the strafe gains
        strafe_r <= (in_vx != '0) && (in_vy == '0) && (in_w == '0);
      end else begin
        vx_r     <= '0;
        vy_r     <= cmd.vy;
        w_r      <= cmd.w;
        pulse_r  <= cmd.pulse;
        fin_r    <= cmd.stop;
        strafe_r <= 1'b0;
      end
    end
    if (st_r == lfowd_pkg::ST_ROUND) begin
      duty_r[wheel_r] <= duty_w;
      dir_r[wheel_r]  <= dir_w;
    end
    if (st_r == lfowd_pkg::ST_OUT && out_free) begin
      out_tdata_r <= {5'b00000, fin_r, pulse_r, dir_r[2], duty_r[2], dir_r[1], duty_r[1],
                      dir_r[0], duty_r[0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_finish_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[42] |-> out_tdata[41:0] == '0)
    else $error("finish beat carries drive");

  a_no_dir3: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:8] != 2'd3 && out_tdata[19:18] != 2'd3 &&
                   out_tdata[29:28] != 2'd3)
    else $error("illegal wheel direction");

  a_turn_left: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && in_tdata[3:0] == 4'hB |=> !last_right_r)
    else $error("turn side not updated to left");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted beat while busy");

endmodule

/* tb/tb_line_follow_omni_wheel_drive_core.sv */
`timescale 1ns / 1ps

module tb_line_follow_omni_wheel_drive_core;

  localparam int DUTY_CAP        = lfowd_pkg::MAX_DUTY_DEF;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 40;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int REPORT_MAX      = 10;

  localparam logic [2:0] CFG_UNUSED = 3'd7;

  // line codes after inversion, bit3 far left, 1 = sensor on black
  localparam logic [3:0] CODE_LOST        = 4'b0000;
  localparam logic [3:0] CODE_FAR_RIGHT   = 4'b0001;
  localparam logic [3:0] CODE_RIGHT_IN    = 4'b0010;
  localparam logic [3:0] CODE_RIGHT_PAIR  = 4'b0011;
  localparam logic [3:0] CODE_LEFT_IN     = 4'b0100;
  localparam logic [3:0] CODE_CENTRE      = 4'b0110;
  localparam logic [3:0] CODE_RIGHT_THREE = 4'b0111;
  localparam logic [3:0] CODE_FAR_LEFT    = 4'b1000;
  localparam logic [3:0] CODE_LEFT_PAIR   = 4'b1100;
  localparam logic [3:0] CODE_LEFT_THREE  = 4'b1110;
  localparam logic [3:0] CODE_ALL_BLACK   = 4'b1111;

  typedef struct packed {
    logic        op;
    logic [11:0] dur;
    logic [9:0]  w;
    logic [9:0]  vy;
    logic [9:0]  vx;
    logic [3:0]  levels;
  } drive_cmd_t;

  // same bit order as out_tdata[42:0]
  typedef struct packed {
    logic        finished;
    logic [11:0] pulse_ms;
    logic [1:0]  dir_rear;
    logic [7:0]  duty_rear;
    logic [1:0]  dir_right;
    logic [7:0]  duty_right;
    logic [1:0]  dir_left;
    logic [7:0]  duty_left;
  } drive_result_t;

  typedef struct {
    bit            is_cfg;
    logic [2:0]    addr;
    logic [14:0]   value;
    drive_cmd_t    cmd;
    bit            typed;
    drive_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // sensor_levels[3:0], vel_x[13:4], vel_y[23:14], turn_rate[33:24], run_ms[45:34]
  logic [47:0] in_tdata = '0;
  // op[0]
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // duty_left[7:0], dir_left[9:8], duty_right[17:10], dir_right[19:18],
  // duty_rear[27:20], dir_rear[29:28], pulse_ms[41:30], finished[42]
  logic [47:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [14:0] cfg_wdata = '0;

  line_follow_omni_wheel_drive_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // local copy of the drive settings and turn memory
  logic [7:0]  speed_base;
  logic        avoid_on;
  logic [8:0]  rate_small;
  logic [8:0]  rate_large;
  logic [8:0]  rate_search;
  logic [14:0] gain_front;
  logic [14:0] gain_rear;
  logic        turned_right;

  drive_result_t pending_drive[$];
  plan_row_t     plan[$];

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int beats_checked = 0;
  int n_line = 0;
  int n_vel = 0;
  int n_finish = 0;
  int n_sat = 0;
  int n_writes = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // round half away from zero from Q29, clamp, split into {dir, duty}
  function automatic logic [9:0] wheel_split(input longint q29);
    longint unsigned mag;
    longint unsigned r;
    logic [1:0] dir;
    mag = (q29 < 0) ? -q29 : q29;
    r = (mag + 64'd268435456) >> 29;
    if (r > DUTY_CAP) r = DUTY_CAP;
    dir = (r == 0) ? lfowd_pkg::DIR_OFF
                   : ((q29 < 0) ? lfowd_pkg::DIR_REV : lfowd_pkg::DIR_FWD);
    return {dir, r[7:0]};
  endfunction

  function automatic drive_result_t omni_wheels(input int vx, input int vy, input int w);
    drive_result_t res;
    longint l;
    longint rt;
    longint b;
    longint gf;
    longint gr;
    res = '0;
    l  = -longint'(lfowd_pkg::Q_SIN60) * vx + longint'(lfowd_pkg::Q_HALF) * vy +
         longint'(lfowd_pkg::Q_TENTH) * w;
    rt = longint'(lfowd_pkg::Q_SIN60) * vx + longint'(lfowd_pkg::Q_HALF) * vy -
         longint'(lfowd_pkg::Q_TENTH) * w;
    b  = longint'(lfowd_pkg::Q_ONE) * vx + longint'(lfowd_pkg::Q_TENTH) * w;
    gf = longint'(lfowd_pkg::GAIN_ONE);
    gr = longint'(lfowd_pkg::GAIN_ONE);
    // pure strafe uses the separate front and rear gains
    if (vx != 0 && vy == 0 && w == 0) begin
      gf = longint'(gain_front);
      gr = longint'(gain_rear);
    end
    {res.dir_left, res.duty_left}   = wheel_split(l * gf);
    {res.dir_right, res.duty_right} = wheel_split(rt * gf);
    {res.dir_rear, res.duty_rear}   = wheel_split(b * gr);
    return res;
  endfunction

  function automatic drive_result_t predict_drive(input drive_cmd_t c);
    drive_result_t res;
    logic [3:0] code;
    logic [11:0] pulse;
    int vy;
    int w;
    int search;
    if (c.op == lfowd_pkg::OP_VEL) begin
      res = omni_wheels(int'($signed(c.vx)), int'($signed(c.vy)), int'($signed(c.w)));
      res.pulse_ms = c.dur;
      return res;
    end
    code = ~c.levels;
    search = turned_right ? int'(rate_search) : -int'(rate_search);
    vy = int'(speed_base);
    w = 0;
    pulse = lfowd_pkg::PULSE_STRAIGHT;
    case (code)
      CODE_CENTRE: ;
      CODE_LEFT_IN: begin
        turned_right = 1'b0;
        w = -int'(rate_small);
        pulse = lfowd_pkg::PULSE_MICRO;
      end
      CODE_FAR_LEFT, CODE_LEFT_PAIR, CODE_LEFT_THREE: begin
        turned_right = 1'b0;
        w = -int'(rate_large);
        pulse = lfowd_pkg::PULSE_MACRO;
      end
      CODE_RIGHT_IN: begin
        turned_right = 1'b1;
        w = int'(rate_small);
        pulse = lfowd_pkg::PULSE_MICRO;
      end
      CODE_FAR_RIGHT, CODE_RIGHT_PAIR, CODE_RIGHT_THREE: begin
        turned_right = 1'b1;
        w = int'(rate_large);
        pulse = lfowd_pkg::PULSE_MACRO;
      end
      CODE_LOST: begin
        vy = 0;
        w = search;
        pulse = lfowd_pkg::PULSE_SEARCH;
      end
      CODE_ALL_BLACK: begin
        if (avoid_on) begin
          res = '0;
          res.finished = 1'b1;
          return res;
        end
      end
      default: begin
        vy = 0;
        w = search;
      end
    endcase
    res = omni_wheels(0, vy, w);
    res.pulse_ms = pulse;
    return res;
  endfunction

  function automatic drive_cmd_t cmd_of(input logic op, input logic [3:0] lv,
                                        input logic [9:0] vx, input logic [9:0] vy,
                                        input logic [9:0] w, input logic [11:0] dur);
    drive_cmd_t c;
    c.op = op;
    c.levels = lv;
    c.vx = vx;
    c.vy = vy;
    c.w = w;
    c.dur = dur;
    return c;
  endfunction

  function automatic drive_result_t make_result(input logic [7:0] ld, input logic [1:0] lr,
                                                input logic [7:0] rd, input logic [1:0] rr,
                                                input logic [7:0] bd, input logic [1:0] br,
                                                input logic [11:0] pulse, input logic fin);
    drive_result_t res;
    res.duty_left = ld;
    res.dir_left = lr;
    res.duty_right = rd;
    res.dir_right = rr;
    res.duty_rear = bd;
    res.dir_rear = br;
    res.pulse_ms = pulse;
    res.finished = fin;
    return res;
  endfunction

  function automatic plan_row_t step_row(input drive_cmd_t c);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.addr = '0;
    row.value = '0;
    row.cmd = c;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input drive_cmd_t c, input drive_result_t r);
    plan_row_t row;
    row = step_row(c);
    row.typed = 1'b1;
    row.want = r;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [2:0] a, input logic [14:0] v);
    plan_row_t row;
    row = step_row('0);
    row.is_cfg = 1'b1;
    row.addr = a;
    row.value = v;
    return row;
  endfunction

  // half full range, half small values so not every wheel saturates
  function automatic logic [9:0] rand_vel();
    if ($urandom_range(0, 1) != 0) return 10'($urandom_range(0, 1023));
    return 10'(int'($urandom_range(0, 127)) - 64);
  endfunction

  task automatic send_cmd(input drive_cmd_t c, input bit typed, input drive_result_t want);
    drive_result_t res;
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.op;
    in_tdata <= {2'b00, c.dur, c.w, c.vy, c.vx, c.levels};
    do @(posedge clk); while (!in_tready);
    res = predict_drive(c);
    if (typed) res = want;
    pending_drive.push_back(res);
    if (c.op == lfowd_pkg::OP_VEL) n_vel++;
    else n_line++;
    if (res.finished) n_finish++;
    if (res.duty_left == 8'hFF || res.duty_right == 8'hFF || res.duty_rear == 8'hFF) n_sat++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [14:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    case (addr)
      lfowd_pkg::CFG_CRUISE_SPEED: speed_base = value[7:0];
      lfowd_pkg::CFG_AVOIDED_MODE: avoid_on = value[0];
      lfowd_pkg::CFG_TURN_SMALL:   rate_small = value[8:0];
      lfowd_pkg::CFG_TURN_LARGE:   rate_large = value[8:0];
      lfowd_pkg::CFG_TURN_SEARCH:  rate_search = value[8:0];
      lfowd_pkg::CFG_GAIN_FRONT:   gain_front = value;
      lfowd_pkg::CFG_GAIN_REAR:    gain_rear = value;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // receiver: random stalls, a long hold-off on request, none while calm
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 38);
    end
  end

  always @(posedge clk) begin
    drive_result_t want;
    drive_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[42:0];
      if (pending_drive.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("unexpected output beat %h", out_tdata);
      end else begin
        want = pending_drive.pop_front();
        beats_checked++;
        if (got.duty_left !== want.duty_left || got.dir_left !== want.dir_left ||
            got.duty_right !== want.duty_right || got.dir_right !== want.dir_right ||
            got.duty_rear !== want.duty_rear || got.dir_rear !== want.dir_rear ||
            got.pulse_ms !== want.pulse_ms || got.finished !== want.finished) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("beat %0d mismatch: want L %0d/%0d R %0d/%0d B %0d/%0d p %0d f %0d",
                     beats_checked, want.duty_left, want.dir_left, want.duty_right,
                     want.dir_right, want.duty_rear, want.dir_rear, want.pulse_ms,
                     want.finished);
            $display("                 got  L %0d/%0d R %0d/%0d B %0d/%0d p %0d f %0d",
                     got.duty_left, got.dir_left, got.duty_right, got.dir_right,
                     got.duty_rear, got.dir_rear, got.pulse_ms, got.finished);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    drive_cmd_t c;
    logic [2:0] idx;
    logic [14:0] val;

    speed_base = 8'd80;
    avoid_on = 1'b0;
    rate_small = 9'd12;
    rate_large = 9'd15;
    rate_search = 9'd300;
    gain_front = 15'd13926;
    gain_rear = 15'd18678;
    turned_right = 1'b0;

    // line walk under reset settings, ignored fields at their extremes on some rows
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'hF, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'h9, 10'h1FF, 10'h200, 10'h155,
                                   12'hFFF)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'hB, 10'h200, 10'h1FF, 10'h2AA,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'h7, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'h3, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'h1, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'hF, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'hD, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'hE, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'hC, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'h8, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'hF, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'hA, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'h6, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'h0, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    // direct commands: all zero, strafe extremes, full-scale mixes, pure spin
    plan.push_back(typed_row(cmd_of(lfowd_pkg::OP_VEL, 4'h0, 10'h000, 10'h000, 10'h000,
                                    12'hFFF),
                             make_result(8'd0, lfowd_pkg::DIR_OFF, 8'd0, lfowd_pkg::DIR_OFF,
                                         8'd0, lfowd_pkg::DIR_OFF, 12'd4095, 1'b0)));
    plan.push_back(typed_row(cmd_of(lfowd_pkg::OP_VEL, 4'hF, 10'h1FF, 10'h000, 10'h000,
                                    12'h123),
                             make_result(8'd255, lfowd_pkg::DIR_REV, 8'd255,
                                         lfowd_pkg::DIR_FWD, 8'd255, lfowd_pkg::DIR_FWD,
                                         12'h123, 1'b0)));
    plan.push_back(typed_row(cmd_of(lfowd_pkg::OP_VEL, 4'h5, 10'h200, 10'h000, 10'h000,
                                    12'h000),
                             make_result(8'd255, lfowd_pkg::DIR_FWD, 8'd255,
                                         lfowd_pkg::DIR_REV, 8'd255, lfowd_pkg::DIR_REV,
                                         12'd0, 1'b0)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_VEL, 4'h0, 10'h1FF, 10'h1FF, 10'h1FF,
                                   12'hAAA)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_VEL, 4'hF, 10'h200, 10'h200, 10'h200,
                                   12'h555)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_VEL, 4'hA, 10'h000, 10'h000, 10'h1FF,
                                   12'h001)));
    // all black with avoided mode stops and finishes
    plan.push_back(cfg_row(lfowd_pkg::CFG_AVOIDED_MODE, 15'h0001));
    plan.push_back(typed_row(cmd_of(lfowd_pkg::OP_LINE, 4'h0, 10'h1FF, 10'h1FF, 10'h1FF,
                                    12'hFFF),
                             make_result(8'd0, lfowd_pkg::DIR_OFF, 8'd0, lfowd_pkg::DIR_OFF,
                                         8'd0, lfowd_pkg::DIR_OFF, 12'd0, 1'b1)));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'hF, 10'h000, 10'h000, 10'h000,
                                   12'h000)));
    // upper bits are dropped, so this clears the mode; out-of-list index does nothing
    plan.push_back(cfg_row(lfowd_pkg::CFG_AVOIDED_MODE, 15'h7FFE));
    plan.push_back(cfg_row(CFG_UNUSED, 15'h7FFF));
    plan.push_back(step_row(cmd_of(lfowd_pkg::OP_LINE, 4'h0, 10'h000, 10'h000, 10'h000,
                                   12'h000)));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].addr, plan[i].value);
      end else begin
        send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
      end
    end

    // phase 0 all registers at max, phase 1 all zero, the rest random
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      for (idx = lfowd_pkg::CFG_CRUISE_SPEED; idx <= lfowd_pkg::CFG_GAIN_REAR; idx++) begin
        val = (ph == 0) ? 15'h7FFF : ((ph == 1) ? 15'h0000 : 15'($urandom_range(0, 32767)));
        write_reg(idx, val);
      end
      calm = (ph == 3);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        c.op = ($urandom_range(0, 1) != 0) ? lfowd_pkg::OP_VEL : lfowd_pkg::OP_LINE;
        c.levels = 4'($urandom_range(0, 15));
        c.dur = 12'($urandom_range(0, 4095));
        c.vx = rand_vel();
        c.vy = rand_vel();
        c.w = rand_vel();
        if (c.op == lfowd_pkg::OP_VEL && $urandom_range(0, 3) == 0) begin
          c.vy = '0;
          c.w = '0;
        end
        send_cmd(c, 1'b0, '0);
      end
      calm = 1'b0;
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d line steps and %0d direct commands, %0d finish stops, %0d saturated",
             n_line, n_vel, n_finish, n_sat);
    $display("%0d register writes over %0d setting phases, %0d beats checked, %0d mismatches",
             n_writes, PHASES + 1, beats_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
